### rtl/smpte_bar_nv12_generator_unit_defines.svh
// Assertion helpers used by the top level of the bar pattern source.
// All of them sample on i_clk and are off while i_rst_n is low.
`ifndef SMPTE_BAR_NV12_GENERATOR_UNIT_DEFINES_SVH
`define SMPTE_BAR_NV12_GENERATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBNV12_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbnv12 same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SBNV12_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbnv12 next-cycle check failed");

`endif

### rtl/sbnv12_pkg.sv
`timescale 1ns / 1ps
package sbnv12_pkg;

    // Default geometry limits and frame number width.
    localparam int DEF_MAX_WIDTH         = 4096;
    localparam int DEF_MAX_HEIGHT        = 4096;
    localparam int DEF_FRAME_NUMBER_BITS = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 13'd480;

    // Component selects into the bar color table.
    localparam int BAR_COUNT = 7;
    localparam logic [1:0] COMP_Y = 2'd0;
    localparam logic [1:0] COMP_U = 2'd1;
    localparam logic [1:0] COMP_V = 2'd2;

    localparam logic [7:0] BAR_YUV [0:BAR_COUNT-1][0:2] = '{
        '{8'd235, 8'd128, 8'd128},
        '{8'd210, 8'd16,  8'd146},
        '{8'd170, 8'd166, 8'd16 },
        '{8'd145, 8'd54,  8'd34 },
        '{8'd106, 8'd202, 8'd222},
        '{8'd81,  8'd90,  8'd240},
        '{8'd41,  8'd240, 8'd110}
    };

    // One output word of the stream.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_chroma;
        logic        end_of_frame;
        logic [31:0] frame_number;
        logic        status;
    } t_result;

    // Position control from the top level to the pattern walker.
    typedef struct packed {
        logic step;
        logic restart;
    } t_pat_ctrl;

    // Table lookup; the bar index never exceeds six.
    function automatic logic [7:0] f_bar_byte(input logic [2:0] bar, input logic [1:0] comp);
        logic [2:0] b;
        logic [1:0] c;
        b = (bar > 3'd6) ? 3'd6 : bar;
        c = (comp > COMP_V) ? COMP_V : comp;
        return BAR_YUV[b][c];
    endfunction

endpackage

### rtl/smpte_bar_nv12_generator_unit.sv
`timescale 1ns / 1ps
// An accepted word's result is registered into the output register, or into the skid register on a stall.
// Throughput: one word per cycle while the skid register is empty; the next position and bar compare are combinational.
// A skid register lets the input take a word while a finished result waits on a stall.
// Reset (synchronous, active low) closes the source, sets 640 x 480, clears the
// position and the frame number, and empties both output registers.
module smpte_bar_nv12_generator_unit #(
    parameter int MAX_WIDTH         = sbnv12_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT        = sbnv12_pkg::DEF_MAX_HEIGHT,
    parameter int FRAME_NUMBER_BITS = sbnv12_pkg::DEF_FRAME_NUMBER_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic [sbnv12_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sbnv12_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_advance,
    // Result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [7:0]                        o_data_byte,
    output logic                              o_is_chroma,
    output logic                              o_end_of_frame,
    output logic [31:0]                       o_frame_number,
    output logic                              o_status
);
    import sbnv12_pkg::*;

    `include "smpte_bar_nv12_generator_unit_defines.svh"

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int CMP_A = (WB > HB) ? WB : HB;
    localparam int CMP_W = (CMP_A > CFG_DATA_W) ? CMP_A : CFG_DATA_W;
    localparam int MAX_W_EVEN = MAX_WIDTH - (MAX_WIDTH % 2);
    localparam int MAX_H_EVEN = MAX_HEIGHT - (MAX_HEIGHT % 2);

    logic                  r_enable;
    logic [CFG_DATA_W-1:0] r_width;
    logic [CFG_DATA_W-1:0] r_height;

    logic [CMP_W-1:0] width_even;
    logic [CMP_W-1:0] height_even;
    logic [CMP_W-1:0] width_clamp;
    logic [CMP_W-1:0] height_clamp;

    t_pat_ctrl pat_ctrl;
    t_result   pat_result;

    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;

    logic in_acc;
    logic out_take;
    logic new_word;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_IDX_ENABLE) begin
                r_enable <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_IDX_WIDTH) begin
                r_width <= i_cfg_data;
            end else if (i_cfg_index == CFG_IDX_HEIGHT) begin
                r_height <= i_cfg_data;
            end
        end
    end

    // Force the size even and into the supported range.
    always_comb begin
        width_even  = CMP_W'({r_width[CFG_DATA_W-1:1], 1'b0});
        height_even = CMP_W'({r_height[CFG_DATA_W-1:1], 1'b0});
        if (width_even > CMP_W'(MAX_W_EVEN)) begin
            width_clamp = CMP_W'(MAX_W_EVEN);
        end else if (width_even < CMP_W'(2)) begin
            width_clamp = CMP_W'(2);
        end else begin
            width_clamp = width_even;
        end
        if (height_even > CMP_W'(MAX_H_EVEN)) begin
            height_clamp = CMP_W'(MAX_H_EVEN);
        end else if (height_even < CMP_W'(2)) begin
            height_clamp = CMP_W'(2);
        end else begin
            height_clamp = height_even;
        end
    end

    // Handshake decode.
    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid & ~r_skid_valid;
    assign new_word   = in_acc & i_advance;
    assign out_take   = r_out_valid & ~i_out_stall;

    assign pat_ctrl.step    = new_word & r_enable;
    assign pat_ctrl.restart = i_cfg_we & (i_cfg_index == CFG_IDX_ENABLE);

    sbnv12_pattern #(
        .MAX_WIDTH         (MAX_WIDTH),
        .MAX_HEIGHT        (MAX_HEIGHT),
        .FRAME_NUMBER_BITS (FRAME_NUMBER_BITS)
    ) u_pattern (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (pat_ctrl),
        .i_enable (r_enable),
        .i_width  (width_clamp[WB-1:0]),
        .i_height (height_clamp[HB-1:0]),
        .o_result (pat_result)
    );

    // Output register with a skid word behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= new_word;
            end
        end else if (new_word) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= pat_result;
            end
        end else if (new_word) begin
            r_skid <= pat_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_data_byte    = r_out.data_byte;
    assign o_is_chroma    = r_out.is_chroma;
    assign o_end_of_frame = r_out.end_of_frame;
    assign o_frame_number = r_out.frame_number;
    assign o_status       = r_out.status;

    // The skid word is only ever filled behind a held output word.
    `SBNV12_ASSERT_SAME(a_skid_behind_out, r_skid_valid, r_out_valid)
    // A new word arriving while the output is held and stalled lands in the skid register.
    `SBNV12_ASSERT_NEXT(a_skid_fill, r_out_valid && i_out_stall && new_word, r_skid_valid)
    // A word taken into an empty output shows the source state it saw.
    `SBNV12_ASSERT_NEXT(a_status_follows_enable, new_word && !r_out_valid && !r_skid_valid,
                        o_out_valid && (o_status == $past(!r_enable)))

endmodule

### rtl/sbnv12_pattern.sv
`timescale 1ns / 1ps
module sbnv12_pattern #(
    parameter int MAX_WIDTH         = sbnv12_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT        = sbnv12_pkg::DEF_MAX_HEIGHT,
    parameter int FRAME_NUMBER_BITS = sbnv12_pkg::DEF_FRAME_NUMBER_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sbnv12_pkg::t_pat_ctrl             i_ctrl,
    input  logic                              i_enable,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    i_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   i_height,
    output sbnv12_pkg::t_result               o_result
);
    import sbnv12_pkg::*;

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int CB = $clog2(MAX_WIDTH);
    localparam int RB = $clog2(MAX_HEIGHT);
    // Product width for column * 7 against multiples of the width.
    localparam int PW = WB + 3;
    localparam int XW = (CB + 1 > WB) ? CB + 1 : WB;
    localparam int YW = (RB + 1 > HB) ? RB + 1 : HB;

    logic [CB-1:0]                r_col, n_col;
    logic [RB-1:0]                r_row, n_row;
    logic                         r_chroma, n_chroma;
    logic [FRAME_NUMBER_BITS-1:0] r_frame, n_frame;

    logic [CB-1:0]   bar_col;
    logic [PW-1:0]   col7;
    logic [2:0]      bar;
    logic [1:0]      comp;
    logic [HB-1:0]   rows;
    logic            last_col;
    logic            last_row;
    logic            eof;
    logic [FRAME_NUMBER_BITS+31:0] frame_ext;

    // Bar index: count how many of the six bar edges the column has passed.
    always_comb begin
        bar_col = r_chroma ? {r_col[CB-1:1], 1'b0} : r_col;
        col7    = (PW'(bar_col) << 3) - PW'(bar_col);
        bar     = 3'd0;
        for (int k = 1; k < BAR_COUNT; k++) begin
            if (col7 >= PW'(k) * PW'(i_width)) begin
                bar = bar + 3'd1;
            end
        end
        if (!r_chroma) begin
            comp = COMP_Y;
        end else if (r_col[0]) begin
            comp = COMP_V;
        end else begin
            comp = COMP_U;
        end
    end

    // Row and plane ends.
    always_comb begin
        rows     = r_chroma ? {1'b0, i_height[HB-1:1]} : i_height;
        last_col = (XW'(r_col) + XW'(1)) >= XW'(i_width);
        last_row = (YW'(r_row) + YW'(1)) >= YW'(rows);
        eof      = r_chroma & last_col & last_row;
    end

    // Next position after one word, or the first position and frame zero on a restart.
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_chroma = r_chroma;
        n_frame  = r_frame;
        if (i_ctrl.restart) begin
            n_col    = '0;
            n_row    = '0;
            n_chroma = 1'b0;
            n_frame  = '0;
        end else if (i_ctrl.step) begin
            if (!last_col) begin
                n_col = r_col + CB'(1);
            end else begin
                n_col = '0;
                if (!last_row) begin
                    n_row = r_row + RB'(1);
                end else begin
                    n_row    = '0;
                    n_chroma = ~r_chroma;
                    if (r_chroma) begin
                        n_frame = r_frame + FRAME_NUMBER_BITS'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_chroma <= 1'b0;
            r_frame  <= '0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_chroma <= n_chroma;
            r_frame  <= n_frame;
        end
    end

    // Result word for the current position; a closed source reports status only.
    always_comb begin
        frame_ext = {32'd0, r_frame};
        o_result  = '0;
        if (i_enable) begin
            o_result.data_byte    = f_bar_byte(bar, comp);
            o_result.is_chroma    = r_chroma;
            o_result.end_of_frame = eof;
            o_result.frame_number = frame_ext[31:0];
            o_result.status       = 1'b0;
        end else begin
            o_result.status = 1'b1;
        end
    end

endmodule
